[sv/i2cms_pkg.sv]
// ----------------------------------------------------------------------------
// i2cms_pkg
// Shared types and codes of the I2C master message sequencer: command codes,
// bus actions, sequencer states, and the item structs of both queue ports.
// ----------------------------------------------------------------------------
package i2cms_pkg;

    // Entries of the small decoupling queues on either side of the engine
    localparam int Q_ENTRIES = 2;
    localparam int Q_PTR_W   = 1;
    localparam int Q_CNT_W   = 2;

    typedef enum logic [1:0] {
        CMD_APPEND = 2'd0,
        CMD_START  = 2'd1,
        CMD_EVENT  = 2'd2
    } t_cmd_code;

    typedef enum logic [1:0] {
        OP_NOP    = 2'd0,
        OP_APPEND = 2'd1,
        OP_START  = 2'd2,
        OP_EVENT  = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ACT_NONE    = 3'd0,
        ACT_START   = 3'd1,
        ACT_RESTART = 3'd2,
        ACT_STOP    = 3'd3,
        ACT_TX      = 3'd4,
        ACT_RCEN    = 3'd5,
        ACT_ACK     = 3'd6,
        ACT_RELEASE = 3'd7
    } t_bus_action;

    typedef enum logic [2:0] {
        SEQ_IDLE     = 3'd0,
        SEQ_START    = 3'd1,
        SEQ_TRANSMIT = 3'd2,
        SEQ_RESTART  = 3'd3,
        SEQ_STOP     = 3'd4
    } t_seq_state;

    typedef enum logic [1:0] {
        PH_RUN   = 2'd0,
        PH_EVENT = 2'd1,
        PH_COPY  = 2'd2
    } t_eng_phase;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] data_byte;
        logic       msg_is_read;
        logic [4:0] msg_length;
        logic       end_of_message;
        logic       bus_collision;
        logic       write_collision;
        logic       receive_overflow;
        logic [7:0] rx_byte;
    } t_in_item;

    // Classified command handed from the front to the engine
    typedef struct packed {
        t_op        op;
        logic [7:0] data_byte;
        logic       msg_is_read;
        logic [4:0] msg_length;
        logic       end_of_message;
        logic       bus_collision;
        logic       discard;
        logic [7:0] rx_byte;
    } t_cmd;

    typedef struct packed {
        t_bus_action bus_action;
        logic [7:0]  tx_byte;
        logic        ack_level;
        logic        rx_valid;
        logic [7:0]  rx_data;
        logic        busy_res;
        logic        queue_pending;
        logic        append_dropped;
    } t_res;

endpackage

[sv/i2c_master_message_sequencer.sv]
// ----------------------------------------------------------------------------
// i2c_master_message_sequencer
// I2C master sequencer with a ring of queued messages. Append beats build
// write or read messages, start requests launch the oldest one, and bus
// completion events step the transfer, one result beat per input beat.
//
//   channel  | handshake          | payload
//   ---------+--------------------+-----------------------------
//   input    | push / full        | i_item   (t_in_item)
//   result   | pop / empty        | o_result (t_res)
//
// Appends, start requests and unused codes are evaluated directly; a bus
// event first reads its byte from the current message buffer. A start,
// or a restart into the next message, then copies the slot into that
// buffer, holding later beats in the queue while the copy runs. Reset is
// synchronous and clears the control state but for the copy slot and
// write index; stores need no clearing.
// ----------------------------------------------------------------------------
module i2c_master_message_sequencer
    import i2cms_pkg::*;
#(
    parameter int QUEUE_DEPTH = 8,
    parameter int MAX_BYTES   = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     push,
    output logic     full,
    input  t_in_item i_item,
    output logic     empty,
    input  logic     pop,
    output t_res     o_result
);

    logic w_cmd_valid;
    t_cmd w_cmd;
    logic w_cmd_pop;
    logic w_res_push;
    t_res w_res;
    logic w_res_full;

    i2cms_front #(
        .MAX_BYTES (MAX_BYTES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_item      (i_item),
        .o_full      (full),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_pop   (w_cmd_pop)
    );

    i2cms_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .MAX_BYTES   (MAX_BYTES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_pop   (w_cmd_pop),
        .o_res_push  (w_res_push),
        .o_res       (w_res),
        .i_res_full  (w_res_full)
    );

    i2cms_res_queue u_res_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_res   (w_res),
        .o_full  (w_res_full),
        .o_empty (empty),
        .o_res   (o_result),
        .i_pop   (pop)
    );

endmodule

[sv/i2cms_front.sv]
// ----------------------------------------------------------------------------
// i2cms_front
// Input side: decodes each incoming beat into an engine command (saturating
// the message length, folding the discard flags) and holds it in a
// two-entry queue until the engine takes it.
// ----------------------------------------------------------------------------
module i2cms_front
    import i2cms_pkg::*;
#(
    parameter int MAX_BYTES = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_in_item i_item,
    output logic     o_full,
    output logic     o_cmd_valid,
    output t_cmd     o_cmd,
    input  logic     i_cmd_pop
);

    t_cmd               w_cmd;
    logic               w_push_ok;
    t_cmd               r_q [Q_ENTRIES];
    logic [Q_PTR_W-1:0] r_wp;
    logic [Q_PTR_W-1:0] r_rp;
    logic [Q_CNT_W-1:0] r_cnt;
    logic [Q_PTR_W-1:0] n_wp;
    logic [Q_PTR_W-1:0] n_rp;
    logic [Q_CNT_W-1:0] n_cnt;

    always_comb begin
        w_cmd.data_byte      = i_item.data_byte;
        w_cmd.msg_is_read    = i_item.msg_is_read;
        w_cmd.end_of_message = i_item.end_of_message;
        w_cmd.bus_collision  = i_item.bus_collision;
        w_cmd.discard        = i_item.write_collision | i_item.receive_overflow;
        w_cmd.rx_byte        = i_item.rx_byte;
        // clamp the length to the slot size
        if (int'(i_item.msg_length) > MAX_BYTES) begin
            w_cmd.msg_length = 5'(MAX_BYTES);
        end else begin
            w_cmd.msg_length = i_item.msg_length;
        end
        unique case (i_item.command)
            CMD_APPEND: w_cmd.op = OP_APPEND;
            CMD_START:  w_cmd.op = OP_START;
            CMD_EVENT:  w_cmd.op = OP_EVENT;
            default:    w_cmd.op = OP_NOP;
        endcase
    end

    assign o_full      = (r_cnt == Q_CNT_W'(Q_ENTRIES));
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rp];
    assign w_push_ok   = i_push && !o_full;

    always_comb begin
        n_wp  = w_push_ok ? r_wp + 1'b1 : r_wp;
        n_rp  = i_cmd_pop ? r_rp + 1'b1 : r_rp;
        n_cnt = r_cnt + Q_CNT_W'(w_push_ok) - Q_CNT_W'(i_cmd_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push_ok) begin
            r_q[r_wp] <= w_cmd;
        end
    end

endmodule

[sv/i2cms_res_queue.sv]
// ----------------------------------------------------------------------------
// i2cms_res_queue
// Output side: two-entry result queue that lets the engine finish the next
// command while an earlier result still waits to be popped.
// ----------------------------------------------------------------------------
module i2cms_res_queue
    import i2cms_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_res i_res,
    output logic o_full,
    output logic o_empty,
    output t_res o_res,
    input  logic i_pop
);

    t_res               r_q [Q_ENTRIES];
    logic [Q_PTR_W-1:0] r_wp;
    logic [Q_PTR_W-1:0] r_rp;
    logic [Q_CNT_W-1:0] r_cnt;
    logic               w_pop_ok;

    assign o_full   = (r_cnt == Q_CNT_W'(Q_ENTRIES));
    assign o_empty  = (r_cnt == '0);
    assign o_res    = r_q[r_rp];
    assign w_pop_ok = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_pop_ok) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + Q_CNT_W'(i_push) - Q_CNT_W'(w_pop_ok);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wp] <= i_res;
        end
    end

endmodule

[sv/i2cms_back.sv]
// ----------------------------------------------------------------------------
// i2cms_back
// Sequencing engine: owns the message ring (byte store and info store), the
// current message buffer and the bus sequencer. Takes one command at a time
// from the front queue and pushes one result per command.
// ----------------------------------------------------------------------------
module i2cms_back
    import i2cms_pkg::*;
#(
    parameter int QUEUE_DEPTH = 8,
    parameter int MAX_BYTES   = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cmd_valid,
    input  t_cmd i_cmd,
    output logic o_cmd_pop,
    output logic o_res_push,
    output t_res o_res,
    input  logic i_res_full
);

    localparam int QW   = $clog2(QUEUE_DEPTH);
    localparam int CW   = $clog2(QUEUE_DEPTH + 1);
    localparam int FW   = $clog2(MAX_BYTES + 1);
    localparam int LW   = $clog2(MAX_BYTES + 1);
    localparam int BW   = $clog2(MAX_BYTES);
    localparam int CNTW = $clog2(MAX_BYTES + 2);
    localparam int QBD  = QUEUE_DEPTH * MAX_BYTES;
    localparam int AW   = $clog2(QBD);

    // Control and sequencer state
    t_eng_phase       r_phase, n_phase;
    t_seq_state       r_seq, n_seq;
    logic [CNTW-1:0]  r_bc, n_bc;
    logic             r_rx_phase, n_rx_phase;
    logic             r_cur_is_read;
    logic [LW-1:0]    r_cur_len;
    logic [QW-1:0]    r_head, n_head;
    logic [QW-1:0]    r_tail, n_tail;
    logic [CW-1:0]    r_count, n_count;
    logic [FW-1:0]    r_fill, n_fill;

    // Message copy sweep
    logic [QW-1:0]    r_cp_slot, n_cp_slot;
    logic [FW-1:0]    r_cp_idx, n_cp_idx;
    logic [BW-1:0]    r_cp_widx, n_cp_widx;
    logic             r_cp_wr, n_cp_wr;
    logic             r_cp_info, n_cp_info;

    // Memories and their read registers
    logic [7:0]       r_qb [QBD];
    logic [LW:0]      r_qi [QUEUE_DEPTH];
    logic [7:0]       r_cur [MAX_BYTES];
    logic [7:0]       r_qb_q;
    logic [LW:0]      r_qi_q;
    logic [7:0]       r_cur_q;

    // Command evaluation
    logic             w_run_fire, w_ev_issue, w_ev_fire, w_fire;
    logic [CNTW-1:0]  w_b;
    logic [BW-1:0]    w_cur_ridx;
    logic [QW-1:0]    w_head_next, w_tail_next;
    t_bus_action      e_act;
    logic [7:0]       e_tx;
    logic             e_ack, e_rxv;
    logic [7:0]       e_rxd;
    t_seq_state       e_seq;
    logic [CNTW-1:0]  e_bc;
    logic             e_rph, e_take, e_qb_we, e_commit, e_dropped;
    logic [FW-1:0]    e_fill;
    logic [CW-1:0]    e_count;

    // Memory ports
    logic             w_qb_re;
    logic [AW-1:0]    w_qb_raddr, w_qb_waddr;

    assign w_run_fire = (r_phase == PH_RUN) && i_cmd_valid && (i_cmd.op != OP_EVENT)
                        && !i_res_full;
    assign w_ev_issue = (r_phase == PH_RUN) && i_cmd_valid && (i_cmd.op == OP_EVENT);
    assign w_ev_fire  = (r_phase == PH_EVENT) && !i_res_full;
    assign w_fire     = w_run_fire || w_ev_fire;

    assign w_b         = (r_seq == SEQ_TRANSMIT) ? r_bc : '0;
    assign w_head_next = (r_head == QW'(QUEUE_DEPTH - 1)) ? '0 : r_head + 1'b1;
    assign w_tail_next = (r_tail == QW'(QUEUE_DEPTH - 1)) ? '0 : r_tail + 1'b1;

    // Byte a bus event may transmit: address byte, or next write byte
    always_comb begin
        if ((r_seq == SEQ_TRANSMIT) && !r_cur_is_read && (r_bc < CNTW'(MAX_BYTES))) begin
            w_cur_ridx = BW'(r_bc);
        end else begin
            w_cur_ridx = '0;
        end
    end

    // Evaluate the command at the head of the front queue
    always_comb begin
        e_act     = ACT_NONE;
        e_tx      = '0;
        e_ack     = 1'b0;
        e_rxv     = 1'b0;
        e_rxd     = '0;
        e_seq     = r_seq;
        e_bc      = r_bc;
        e_rph     = r_rx_phase;
        e_take    = 1'b0;
        e_qb_we   = 1'b0;
        e_commit  = 1'b0;
        e_dropped = 1'b0;
        e_fill    = r_fill;
        unique case (i_cmd.op)
            OP_APPEND: begin
                if (r_count >= CW'(QUEUE_DEPTH)) begin
                    e_dropped = 1'b1;
                end else begin
                    if (r_fill < FW'(MAX_BYTES)) begin
                        e_qb_we = 1'b1;
                        e_fill  = r_fill + 1'b1;
                    end
                    if (i_cmd.end_of_message) begin
                        e_commit = 1'b1;
                        e_fill   = '0;
                    end
                end
            end
            OP_START: begin
                if ((r_seq == SEQ_IDLE) && (r_count != '0)) begin
                    e_take = 1'b1;
                    e_seq  = SEQ_START;
                    e_act  = ACT_START;
                end
            end
            OP_EVENT: begin
                if (i_cmd.bus_collision && (r_seq == SEQ_START)) begin
                    e_act = ACT_RELEASE;
                end else if (i_cmd.discard) begin
                    e_act = ACT_NONE;
                end else if ((r_seq == SEQ_START) || (r_seq == SEQ_RESTART)
                             || (r_seq == SEQ_TRANSMIT)) begin
                    e_seq = SEQ_TRANSMIT;
                    e_bc  = w_b;
                    if (r_cur_is_read) begin
                        if (w_b == '0) begin
                            e_act = ACT_TX;
                            e_tx  = r_cur_q;
                            e_bc  = CNTW'(1);
                        end else if (w_b <= CNTW'(r_cur_len)) begin
                            if (!r_rx_phase) begin
                                e_act = ACT_RCEN;
                                e_rph = 1'b1;
                            end else begin
                                e_act = ACT_ACK;
                                e_rxv = 1'b1;
                                e_rxd = i_cmd.rx_byte;
                                e_ack = (w_b == CNTW'(r_cur_len));
                                e_rph = 1'b0;
                                e_bc  = w_b + 1'b1;
                            end
                        end else begin
                            e_bc  = '0;
                            e_seq = SEQ_STOP;
                            e_act = ACT_STOP;
                        end
                    end else begin
                        if (w_b < CNTW'(r_cur_len)) begin
                            e_act = ACT_TX;
                            e_tx  = r_cur_q;
                            e_bc  = w_b + 1'b1;
                        end else if (r_count != '0) begin
                            // chain straight into the next queued message
                            e_take = 1'b1;
                            e_seq  = SEQ_RESTART;
                            e_act  = ACT_RESTART;
                        end else begin
                            e_seq = SEQ_STOP;
                            e_act = ACT_STOP;
                        end
                    end
                end else begin
                    e_seq = SEQ_IDLE;
                end
            end
            default: begin
            end
        endcase
        e_count = r_count + CW'(e_commit) - CW'(e_take);
    end

    // Next state
    always_comb begin
        n_phase    = r_phase;
        n_seq      = r_seq;
        n_bc       = r_bc;
        n_rx_phase = r_rx_phase;
        n_head     = r_head;
        n_tail     = r_tail;
        n_count    = r_count;
        n_fill     = r_fill;
        n_cp_slot  = r_cp_slot;
        n_cp_idx   = r_cp_idx;
        n_cp_widx  = r_cp_widx;
        n_cp_wr    = 1'b0;
        n_cp_info  = 1'b0;
        if (w_fire) begin
            n_seq      = e_seq;
            n_bc       = e_bc;
            n_rx_phase = e_rph;
            n_count    = e_count;
            n_fill     = e_fill;
            if (e_commit) begin
                n_tail = w_tail_next;
            end
            if (e_take) begin
                n_head    = w_head_next;
                n_cp_slot = r_head;
                n_cp_idx  = FW'(1);
                n_cp_widx = '0;
                n_cp_wr   = 1'b1;
                n_cp_info = 1'b1;
            end
        end
        unique case (r_phase)
            PH_RUN: begin
                if (w_ev_issue) begin
                    n_phase = PH_EVENT;
                end else if (w_run_fire && e_take) begin
                    n_phase = PH_COPY;
                end
            end
            PH_EVENT: begin
                if (w_ev_fire) begin
                    n_phase = e_take ? PH_COPY : PH_RUN;
                end
            end
            PH_COPY: begin
                if (r_cp_idx < FW'(MAX_BYTES)) begin
                    n_cp_wr   = 1'b1;
                    n_cp_widx = BW'(r_cp_idx);
                    n_cp_idx  = r_cp_idx + 1'b1;
                end else begin
                    n_phase = PH_RUN;
                end
            end
            default: n_phase = PH_RUN;
        endcase
    end

    // Outputs and memory ports
    always_comb begin
        o_cmd_pop           = w_fire;
        o_res_push          = w_fire;
        o_res.bus_action    = e_act;
        o_res.tx_byte       = e_tx;
        o_res.ack_level     = e_ack;
        o_res.rx_valid      = e_rxv;
        o_res.rx_data       = e_rxd;
        o_res.busy_res      = (e_seq != SEQ_IDLE);
        o_res.queue_pending = (e_count != '0);
        o_res.append_dropped = e_dropped;
        w_qb_waddr = AW'(r_tail) * AW'(MAX_BYTES) + AW'(r_fill);
        if (r_phase == PH_COPY) begin
            w_qb_re    = (r_cp_idx < FW'(MAX_BYTES));
            w_qb_raddr = AW'(r_cp_slot) * AW'(MAX_BYTES) + AW'(r_cp_idx);
        end else begin
            w_qb_re    = w_fire && e_take;
            w_qb_raddr = AW'(r_head) * AW'(MAX_BYTES);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_RUN;
            r_seq         <= SEQ_IDLE;
            r_bc          <= '0;
            r_rx_phase    <= 1'b0;
            r_cur_is_read <= 1'b0;
            r_cur_len     <= '0;
            r_head        <= '0;
            r_tail        <= '0;
            r_count       <= '0;
            r_fill        <= '0;
            r_cp_idx      <= '0;
            r_cp_wr       <= 1'b0;
            r_cp_info     <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_seq      <= n_seq;
            r_bc       <= n_bc;
            r_rx_phase <= n_rx_phase;
            r_head     <= n_head;
            r_tail     <= n_tail;
            r_count    <= n_count;
            r_fill     <= n_fill;
            r_cp_idx   <= n_cp_idx;
            r_cp_wr    <= n_cp_wr;
            r_cp_info  <= n_cp_info;
            // latch direction and length of the message just taken
            if (r_cp_info) begin
                r_cur_is_read <= r_qi_q[LW];
                r_cur_len     <= r_qi_q[LW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cp_slot <= n_cp_slot;
        r_cp_widx <= n_cp_widx;
    end

    // Message byte store
    always_ff @(posedge i_clk) begin
        if (w_run_fire && e_qb_we) begin
            r_qb[w_qb_waddr] <= i_cmd.data_byte;
        end
        if (w_qb_re) begin
            r_qb_q <= r_qb[w_qb_raddr];
        end
    end

    // Message info store
    always_ff @(posedge i_clk) begin
        if (w_run_fire && e_commit) begin
            r_qi[r_tail] <= {i_cmd.msg_is_read, LW'(i_cmd.msg_length)};
        end
        if (w_fire && e_take) begin
            r_qi_q <= r_qi[r_head];
        end
    end

    // Current message buffer
    always_ff @(posedge i_clk) begin
        if (r_cp_wr) begin
            r_cur[r_cp_widx] <= r_qb_q;
        end
        if (w_ev_issue) begin
            r_cur_q <= r_cur[w_cur_ridx];
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(QUEUE_DEPTH))
        else $error("message count beyond ring depth");

    a_copy_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_COPY) |-> (r_seq != SEQ_IDLE))
        else $error("message copy while sequencer idle");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_push |-> !i_res_full)
        else $error("result pushed into full queue");

    a_copy_write_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_RUN) |-> !r_cp_wr)
        else $error("buffer copy still writing after sweep");

    a_event_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_EVENT) |-> (i_cmd_valid && (i_cmd.op == OP_EVENT)))
        else $error("bus event lost while fetching its byte");
`endif

endmodule
